// ----- design/four_key_debounce_icon_toggle_unit_defines.svh -----
// ----------------------------------------------------------------------------
// four_key_debounce_icon_toggle_unit_defines
// assertion macros shared by the debounce and toggle modules
// ----------------------------------------------------------------------------
`ifndef FOUR_KEY_DEBOUNCE_ICON_TOGGLE_UNIT_DEFINES_SVH
`define FOUR_KEY_DEBOUNCE_ICON_TOGGLE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property checked on every clock edge outside reset
`define FKDIT_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error("fkdit assertion failed");
// property checked on every clock edge, reset included
`define FKDIT_ASSERT_ALWAYS(lbl, clk_s, prop) \
    lbl: assert property (@(posedge clk_s) prop) \
        else $error("fkdit assertion failed");
`else
`define FKDIT_ASSERT(lbl, clk_s, rstn_s, prop)
`define FKDIT_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif

`endif

// ----- design/fkdit_pkg.sv -----
// ----------------------------------------------------------------------------
// fkdit_pkg
// shared types and constants of the key debounce and icon toggle unit
// ----------------------------------------------------------------------------
package fkdit_pkg;

    localparam int NUM_KEYS_DEF = 4;
    localparam int PIN_KEYS     = 4;
    localparam int DATA_W       = 8;
    localparam int KEYNUM_W     = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 16;

    localparam logic [DATA_W-1:0] TICKS_RESET = 8'd20;
    localparam logic [DATA_W-1:0] COUNT_MAX   = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0_MASK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2_MASK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3_MASK    = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PDBNC   = 2'd1,
        PH_PRESSED = 2'd2,
        PH_RDBNC   = 2'd3
    } phase_t;

    typedef struct packed {
        logic                status_valid;
        logic [DATA_W-1:0]   status_byte;
        logic [KEYNUM_W-1:0] key_number;
        logic                last_frame;
    } frame_t;

endpackage

// ----- design/fkdit_lane.sv -----
// ----------------------------------------------------------------------------
// fkdit_lane
// one key debouncer: four-phase state machine with a stable tick counter
// ----------------------------------------------------------------------------
`include "four_key_debounce_icon_toggle_unit_defines.svh"

module fkdit_lane (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tick,
    input  logic                       level,
    input  logic [fkdit_pkg::DATA_W-1:0] stable_ticks,
    output logic                       confirm
);
    import fkdit_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [DATA_W-1:0] count_reg, count_next;
    logic [DATA_W-1:0] count_inc;
    logic              reached;

    assign count_inc = (count_reg < COUNT_MAX) ? count_reg + 8'd1 : count_reg;
    assign reached   = (count_inc >= stable_ticks);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (!level)
                    phase_next = PH_PDBNC;
            end
            PH_PDBNC:
            begin
                if (level)
                    phase_next = PH_IDLE;
                else if (reached)
                    phase_next = PH_PRESSED;
            end
            PH_PRESSED:
            begin
                if (level)
                    phase_next = PH_RDBNC;
            end
            PH_RDBNC:
            begin
                if (!level)
                    phase_next = PH_PRESSED;
                else if (reached)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // counter and press confirm
    always_comb
    begin
        count_next = count_reg;
        confirm    = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (!level)
                    count_next = '0;
            end
            PH_PDBNC:
            begin
                if (!level)
                begin
                    count_next = count_inc;
                    confirm    = reached;
                end
            end
            PH_PRESSED:
            begin
                if (level)
                    count_next = '0;
            end
            PH_RDBNC:
            begin
                if (level)
                    count_next = count_inc;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else if (tick)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    `FKDIT_ASSERT(a_confirm_to_pressed, clk, rst_n,
        (tick && confirm) |=> (phase_reg == PH_PRESSED))
    `FKDIT_ASSERT(a_idle_holds_released, clk, rst_n,
        (tick && level && phase_reg == PH_IDLE) |=> (phase_reg == PH_IDLE))
    `FKDIT_ASSERT(a_confirm_only_debounce, clk, rst_n,
        confirm |-> (phase_reg == PH_PDBNC && !level))

endmodule

// ----- design/fkdit_merge.sv -----
// ----------------------------------------------------------------------------
// fkdit_merge
// merges lane confirms into icon toggles and serializes status frames
// ----------------------------------------------------------------------------
`include "four_key_debounce_icon_toggle_unit_defines.svh"

module fkdit_merge #(
    parameter int NUM_KEYS = fkdit_pkg::NUM_KEYS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     load,
    input  logic [NUM_KEYS-1:0]                      confirms,
    input  logic [NUM_KEYS-1:0][fkdit_pkg::DATA_W-1:0] masks,
    input  logic                                     frame_ready,
    output logic                                     take_ready,
    output fkdit_pkg::frame_t                        frame
);
    import fkdit_pkg::*;

    logic [NUM_KEYS-1:0] pend_reg, pend_next;
    logic [NUM_KEYS-1:0] low_bit, rest;
    logic [DATA_W-1:0]   icon_reg, icon_next;
    logic [DATA_W-1:0]   sel_mask;
    logic [KEYNUM_W-1:0] sel_key;
    logic                adv;
    frame_t              frame_reg, frame_next;

    assign low_bit = pend_reg & (~pend_reg + NUM_KEYS'(1));
    assign rest    = pend_reg & ~low_bit;

    always_comb
    begin
        sel_mask = '0;
        sel_key  = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (low_bit[k])
            begin
                sel_mask = sel_mask | masks[k];
                sel_key  = sel_key | KEYNUM_W'(k);
            end
        end
    end

    assign adv        = (pend_reg != '0) && (!frame_reg.status_valid || frame_ready);
    assign take_ready = (pend_reg == '0) || (adv && rest == '0);
    assign icon_next  = adv ? (icon_reg ^ sel_mask) : icon_reg;

    always_comb
    begin
        if (load)
            pend_next = confirms;
        else if (adv)
            pend_next = rest;
        else
            pend_next = pend_reg;
    end

    always_comb
    begin
        frame_next = frame_reg;
        if (adv)
        begin
            frame_next.status_valid = 1'b1;
            frame_next.status_byte  = icon_next;
            frame_next.key_number   = sel_key;
            frame_next.last_frame   = (rest == '0);
        end
        else if (frame_ready)
        begin
            frame_next.status_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            icon_reg  <= '0;
            frame_reg <= '0;
        end
        else
        begin
            pend_reg  <= pend_next;
            icon_reg  <= icon_next;
            frame_reg <= frame_next;
        end
    end

    assign frame = frame_reg;

    `FKDIT_ASSERT(a_load_when_drained, clk, rst_n,
        load |-> (pend_reg == '0 || (adv && rest == '0)))
    `FKDIT_ASSERT(a_adv_shows_icon, clk, rst_n,
        adv |=> (frame_reg.status_valid && frame_reg.status_byte == icon_reg))
    `FKDIT_ASSERT(a_last_ends_run, clk, rst_n,
        (adv && rest == '0 && !load) |=> (pend_reg == '0 && frame_reg.last_frame))

endmodule

// ----- design/four_key_debounce_icon_toggle_unit.sv -----
// ----------------------------------------------------------------------------
// four_key_debounce_icon_toggle_unit
// debounces active-low keys and toggles an icon bitmap on confirmed presses
// ----------------------------------------------------------------------------
// s_axis carries one scan tick per item: key levels in tdata[3:0].
// cfg writes stable_ticks (index 0) and key masks (index 1 to 4); cfg_ready
// is always high and writes are meant for an idle unit.
// m_axis carries one status frame per confirmed press, in key order, with
// tlast on the final frame of a tick; a tick with no press gives nothing.
// all key lanes step together on the accepted tick; confirms are queued
// in a pending vector and one frame leaves per cycle while the receiver
// is ready; a frame passes the pending vector, then the output register.
// a tick is taken as soon as the previous tick's frames are all in the
// output register, before they leave it; the frames of a tick leave one
// by one through the single frame output port.
// a stalled receiver holds the output register and the pending frames,
// and s_axis_tready stays low until the last pending frame moves out.
// reset puts every key in idle with count zero, clears the icon bitmap
// and loads stable_ticks 20 and masks 1, 2, 4, 8.
// ----------------------------------------------------------------------------
module four_key_debounce_icon_toggle_unit #(
    parameter int NUM_KEYS = fkdit_pkg::NUM_KEYS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [fkdit_pkg::IN_TDATA_W-1:0]       s_axis_tdata,   // key_levels[3:0]
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [fkdit_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // status_byte, key_number
    output logic                                   m_axis_tlast,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [fkdit_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fkdit_pkg::DATA_W-1:0]           cfg_data
);
    import fkdit_pkg::*;

    logic [DATA_W-1:0]                ticks_reg;
    logic [PIN_KEYS-1:0][DATA_W-1:0]  mask_reg;
    logic [NUM_KEYS-1:0][DATA_W-1:0]  lane_masks;
    logic [NUM_KEYS-1:0]              lane_levels;
    logic [NUM_KEYS-1:0]              confirms;
    logic                             take_ready;
    logic                             tick;
    frame_t                           frame;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = take_ready;
    assign tick          = s_axis_tvalid && take_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg   <= TICKS_RESET;
            mask_reg[0] <= 8'd1;
            mask_reg[1] <= 8'd2;
            mask_reg[2] <= 8'd4;
            mask_reg[3] <= 8'd8;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_STABLE_TICKS: ticks_reg   <= cfg_data;
                CFG_KEY0_MASK:    mask_reg[0] <= cfg_data;
                CFG_KEY1_MASK:    mask_reg[1] <= cfg_data;
                CFG_KEY2_MASK:    mask_reg[2] <= cfg_data;
                CFG_KEY3_MASK:    mask_reg[3] <= cfg_data;
                default:          ticks_reg   <= ticks_reg;
            endcase
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        // keys without a pin read as released and toggle nothing
        if (k < PIN_KEYS)
        begin : g_pin
            assign lane_levels[k] = s_axis_tdata[k];
            assign lane_masks[k]  = mask_reg[k];
        end
        else
        begin : g_nopin
            assign lane_levels[k] = 1'b1;
            assign lane_masks[k]  = '0;
        end

        fkdit_lane u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .tick         (tick),
            .level        (lane_levels[k]),
            .stable_ticks (ticks_reg),
            .confirm      (confirms[k])
        );
    end

    fkdit_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (tick),
        .confirms    (confirms),
        .masks       (lane_masks),
        .frame_ready (m_axis_tready),
        .take_ready  (take_ready),
        .frame       (frame)
    );

    assign m_axis_tvalid = frame.status_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - DATA_W - KEYNUM_W){1'b0}},
                            frame.key_number, frame.status_byte};
    assign m_axis_tlast  = frame.last_frame;

endmodule

// ----- bench/tb_four_key_debounce_icon_toggle_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_key_debounce_icon_toggle_unit
// Scan ticks are streamed into the unit and the status frames that come back
// are checked field by field against a local debounce and icon model. The
// run starts with directed key sequences: reset values, bounces, a zero
// threshold, a threshold lowered mid-debounce and writes to unused register
// indexes. Random phases follow with press and release runs under several
// settings, with random gaps and stalls on both streams but in the last phase.
// ----------------------------------------------------------------------------
module tb_four_key_debounce_icon_toggle_unit;
    import fkdit_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_KEY3_MASK + 3'd1;
    localparam logic [PIN_KEYS-1:0]  ALL_RELEASED = 4'b1111;
    localparam logic [PIN_KEYS-1:0]  ALL_PRESSED  = 4'b0000;

    typedef struct {
        logic [DATA_W-1:0]   status_byte;
        logic [KEYNUM_W-1:0] key_number;
        logic                last_frame;
    } status_frame_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // key_levels[3:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // status_byte[7:0], key_number[9:8]
    logic                   m_axis_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DATA_W-1:0]      cfg_data;

    four_key_debounce_icon_toggle_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // local copy of the key debouncers and the icon bitmap
    phase_t            key_phase    [PIN_KEYS];
    logic [DATA_W-1:0] stable_count [PIN_KEYS];
    logic [DATA_W-1:0] key_mask     [PIN_KEYS];
    logic [DATA_W-1:0] confirm_ticks;
    logic [DATA_W-1:0] icon_bits;
    status_frame_t     frames_due[$];

    // press and release run generator
    logic [PIN_KEYS-1:0] scan_levels;
    int                  scan_hold [PIN_KEYS];

    bit sender_gaps_on;
    bit receiver_stalls_on;
    int mismatches;
    int ticks_sent;
    int frames_seen;
    int regs_written;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic count_is_stable(input int k);
        if (stable_count[k] != COUNT_MAX)
            stable_count[k] = stable_count[k] + 8'd1;
        return stable_count[k] >= confirm_ticks;
    endfunction

    function automatic void debounce_and_toggle(input logic [PIN_KEYS-1:0] levels);
        status_frame_t fr;
        int            last_idx;
        last_idx = -1;
        for (int k = 0; k < PIN_KEYS; k++)
        begin
            case (key_phase[k])
                PH_IDLE:
                    if (!levels[k])
                    begin
                        key_phase[k]    = PH_PDBNC;
                        stable_count[k] = '0;
                    end
                PH_PDBNC:
                    if (levels[k])
                        key_phase[k] = PH_IDLE;
                    else if (count_is_stable(k))
                    begin
                        key_phase[k]   = PH_PRESSED;
                        icon_bits      = icon_bits ^ key_mask[k];
                        fr.status_byte = icon_bits;
                        fr.key_number  = KEYNUM_W'(k);
                        fr.last_frame  = 1'b0;
                        frames_due.push_back(fr);
                        last_idx = frames_due.size() - 1;
                    end
                PH_PRESSED:
                    if (levels[k])
                    begin
                        key_phase[k]    = PH_RDBNC;
                        stable_count[k] = '0;
                    end
                default:
                    if (!levels[k])
                        key_phase[k] = PH_PRESSED;
                    else if (count_is_stable(k))
                        key_phase[k] = PH_IDLE;
            endcase
        end
        if (last_idx >= 0)
        begin
            fr = frames_due[last_idx];
            fr.last_frame = 1'b1;
            frames_due[last_idx] = fr;
        end
    endfunction

    function automatic void mirror_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [DATA_W-1:0] value);
        if (idx == CFG_STABLE_TICKS)
            confirm_ticks = value;
        else if (idx <= CFG_KEY3_MASK)
            key_mask[KEYNUM_W'(idx - CFG_KEY0_MASK)] = value;
    endfunction

    function automatic void compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endfunction

    // tvalid stays high after an item so back-to-back items need no toggle
    task automatic send_tick(input logic [PIN_KEYS-1:0] levels);
        if (sender_gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(levels);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        debounce_and_toggle(levels);
        ticks_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mirror_reg_write(idx, value);
        regs_written++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        cfg_valid     <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [DATA_W-1:0] ticks, input logic [DATA_W-1:0] m0,
                                  input logic [DATA_W-1:0] m1, input logic [DATA_W-1:0] m2,
                                  input logic [DATA_W-1:0] m3);
        wait_drained();
        write_reg(CFG_STABLE_TICKS, ticks);
        write_reg(CFG_KEY0_MASK, m0);
        write_reg(CFG_KEY1_MASK, m1);
        write_reg(CFG_KEY2_MASK, m2);
        write_reg(CFG_KEY3_MASK, m3);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_ticks(input logic [PIN_KEYS-1:0] levels, input int count);
        repeat (count) send_tick(levels);
    endtask

    // all keys held from reset: threshold 20 and masks 1, 2, 4, 8
    task automatic test_reset_values();
        send_ticks(ALL_PRESSED, 21);
    endtask

    task automatic test_release_and_zero_mask();
        apply_settings(8'd1, 8'hFF, 8'h00, 8'hA5, 8'h5A);
        send_ticks(ALL_RELEASED, 2);
        send_ticks(4'b1101, 2);
        send_ticks(ALL_RELEASED, 2);
    endtask

    task automatic test_bounce();
        send_tick(4'b1011);
        send_tick(ALL_RELEASED);
        send_ticks(4'b1011, 2);
        send_tick(ALL_RELEASED);
        send_tick(4'b1011);
        send_ticks(ALL_RELEASED, 2);
    endtask

    task automatic test_zero_threshold();
        apply_settings(8'd0, 8'h80, 8'h40, 8'h20, 8'hFF);
        send_ticks(4'b0110, 2);
        send_ticks(ALL_RELEASED, 2);
    endtask

    // count built up under 255, then threshold dropped to 3 with key held
    task automatic test_threshold_lowered();
        apply_settings(8'd255, 8'h3C, 8'hC3, 8'h0F, 8'hF0);
        send_ticks(4'b1110, 6);
        wait_drained();
        write_reg(CFG_STABLE_TICKS, 8'd3);
        for (int i = CFG_SPARE_LO; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), DATA_W'($urandom));
        cfg_valid <= 1'b0;
        send_tick(4'b1110);
        send_ticks(ALL_RELEASED, 4);
    endtask

    // mostly held runs long enough to confirm, some short bounces and noise
    task automatic run_random_phase(input int count, input int ticks, input logic [DATA_W-1:0] m0,
                                    input logic [DATA_W-1:0] m1, input logic [DATA_W-1:0] m2,
                                    input logic [DATA_W-1:0] m3);
        logic [PIN_KEYS-1:0] levels;
        apply_settings(DATA_W'(ticks), m0, m1, m2, m3);
        repeat (count)
        begin
            for (int k = 0; k < PIN_KEYS; k++)
            begin
                if (scan_hold[k] == 0)
                begin
                    scan_levels[k] = ~scan_levels[k];
                    if ($urandom_range(0, 4) != 0)
                        scan_hold[k] = $urandom_range(ticks + 1, ticks + 4);
                    else
                        scan_hold[k] = $urandom_range(1, ticks);
                end
                scan_hold[k]--;
            end
            levels = ($urandom_range(0, 9) == 0) ? PIN_KEYS'($urandom) : scan_levels;
            if (sender_gaps_on && $urandom_range(0, 49) == 0)
                wait_drained();
            send_tick(levels);
        end
    endtask

    task automatic test_random();
        scan_levels = ALL_RELEASED;
        for (int k = 0; k < PIN_KEYS; k++)
            scan_hold[k] = $urandom_range(1, 3);
        run_random_phase(80, 1, DATA_W'($urandom), DATA_W'($urandom),
                         DATA_W'($urandom), DATA_W'($urandom));
        run_random_phase(70, 2, 8'hFF, 8'h00, 8'hFF, 8'h00);
        run_random_phase(80, $urandom_range(3, 6), DATA_W'($urandom), DATA_W'($urandom),
                         DATA_W'($urandom), DATA_W'($urandom));
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        run_random_phase(100, 1, DATA_W'($urandom), DATA_W'($urandom),
                         DATA_W'($urandom), DATA_W'($urandom));
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_STABLE_TICKS;
        cfg_data      <= '0;
        confirm_ticks = TICKS_RESET;
        icon_bits     = '0;
        for (int k = 0; k < PIN_KEYS; k++)
        begin
            key_phase[k]    = PH_IDLE;
            stable_count[k] = '0;
            key_mask[k]     = DATA_W'(1 << k);
        end
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_release_and_zero_mask();
        test_bounce();
        test_zero_threshold();
        test_threshold_lowered();
        test_random();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d key ticks and %0d status frames, %0d register writes,",
                 ticks_sent, frames_seen, regs_written);
        $display("thresholds 0, 1 to 6, 20 and 255, bounces and simultaneous presses");
        if (mismatches == 0)
            $display("tb_four_key_debounce_icon_toggle_unit: done, clean");
        else
            $display("tb_four_key_debounce_icon_toggle_unit: done, errors");
        $finish;
    end

    initial
    begin
        m_axis_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (receiver_stalls_on && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : frame_check
        status_frame_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            frames_seen++;
            if (frames_due.size() == 0)
            begin
                $error("unexpected status frame: tdata %0h tlast %0b", m_axis_tdata, m_axis_tlast);
                mismatches++;
            end
            else
            begin
                want = frames_due.pop_front();
                compare_field("status_byte", want.status_byte, m_axis_tdata[DATA_W-1:0]);
                compare_field("key_number", want.key_number,
                              m_axis_tdata[DATA_W+KEYNUM_W-1:DATA_W]);
                compare_field("tdata_pad", 0, m_axis_tdata[OUT_TDATA_W-1:DATA_W+KEYNUM_W]);
                compare_field("last_frame", want.last_frame, m_axis_tlast);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", quiet_cycles);
            $display("tb_four_key_debounce_icon_toggle_unit: done, errors");
            $finish;
        end
    end

endmodule
